// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL files; empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Property must hold at every clock edge outside reset.
`define AT_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Condition must never be true outside reset.
`define AT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

`else

`define AT_ASSERT(lbl, clk, rst, prop)
`define AT_NEVER(lbl, clk, rst, cond)

`endif

`endif

// ===== hw/rtl/aisd_pkg.sv =====
// Package for the +IPD stream deframer: codes, character constants, helpers.
`timescale 1ns / 1ps

package aisd_pkg;

   localparam int unsigned LEN_BITS_DEFAULT = 16;

   // Parser modes
   localparam logic [2:0] M_LSTART = 3'd0;
   localparam logic [2:0] M_LINE   = 3'd1;
   localparam logic [2:0] M_HID    = 3'd2;
   localparam logic [2:0] M_HLEN   = 3'd3;
   localparam logic [2:0] M_PAY    = 3'd4;

   // Result kinds
   localparam logic [2:0] KIND_PAYLOAD = 3'd0;
   localparam logic [2:0] KIND_CONNECT = 3'd1;
   localparam logic [2:0] KIND_CLOSED  = 3'd2;
   localparam logic [2:0] KIND_BAD_HDR = 3'd3;
   localparam logic [2:0] KIND_EMPTY   = 3'd4;

   // Leading integer phases
   localparam logic [1:0] LP_SKIP      = 2'd0;
   localparam logic [1:0] LP_DIGITS    = 2'd1;
   localparam logic [1:0] LP_DONE_NONE = 2'd2;
   localparam logic [1:0] LP_DONE_INT  = 2'd3;

   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_COMMA = 8'h2C;

   localparam logic [2:0] PFX_LEN   = 3'd5;
   localparam int unsigned TAIL_LEN = 9;
   localparam int unsigned CONN_LEN = 8;
   localparam int unsigned CLOS_LEN = 7;

   // Suffixes stored newest byte first, matching the tail shift order
   localparam logic [7:0] SFX_CONN [CONN_LEN] = '{"T", "C", "E", "N", "N", "O", "C", ","};
   localparam logic [7:0] SFX_CLOS [CLOS_LEN] = '{"D", "E", "S", "O", "L", "C", ","};

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] link;
      logic       link_valid;
      logic [7:0] payload;
      logic       frame_last;
   } res_type;

   function automatic logic [7:0] pfx_char(input logic [2:0] pos);
      logic [7:0] c;
      unique case (pos)
         3'd0:    c = "+";
         3'd1:    c = "I";
         3'd2:    c = "P";
         3'd3:    c = "D";
         3'd4:    c = ",";
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      return (b >= "0") && (b <= "9");
   endfunction

   function automatic logic is_space(input logic [7:0] b);
      return (b == " ") || ((b >= 8'd9) && (b <= 8'd13));
   endfunction

   // acc * 10 + digit, saturating at 255
   function automatic logic [7:0] mac10_u8(input logic [7:0] acc, input logic [7:0] b);
      logic [11:0] v;
      logic [7:0]  d;
      d = b - "0";
      v = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + {8'd0, d[3:0]};
      return (|v[11:8]) ? 8'hFF : v[7:0];
   endfunction

endpackage

// ===== hw/rtl/at_ipd_stream_deframer_top.sv =====
// Top level of the +IPD stream deframer.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Usage
//   req channel: one received modem byte per request (req_rx_byte).
//   rsp channel: at most one result per request: a payload byte tagged with
//   its link id (rsp_frame_last on the final byte), a connect or closed event
//   with the line's leading integer, a malformed-header flag or an empty frame.
//   A request is taken when valid is high and stall is low.
//   Path: a taken byte is loaded into the input register, the parser runs on it
//   there, and its result is loaded into the result register. Throughput: one
//   byte per cycle while req_stall is low, set by the single pass from the input
//   register into the result register.
//   A stalled result is held in the result register; a skid register takes one
//   more, and only then does req_stall rise, holding the pending byte in the
//   input register until the skid register drains.
//   Reset (synchronous) drops all pending requests and results and returns
//   the parser to the start of a line.
module at_ipd_stream_deframer_top
   import aisd_pkg::*;
#(
   parameter int unsigned LEN_BITS = LEN_BITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_kind,
   output logic [7:0] rsp_link,
   output logic       rsp_link_valid,
   output logic [7:0] rsp_payload,
   output logic       rsp_frame_last
);

   localparam logic [LEN_BITS-1:0] LEN_ONE = LEN_BITS'(1);
   localparam logic [LEN_BITS-1:0] LEN_MAX = '1;

   // Input stage
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;

   // Parser state
   logic [2:0]          mode_ff, mode_in;
   logic [2:0]          prefix_pos_ff, prefix_pos_in;
   logic [7:0]          hdr_id_ff, hdr_id_in;
   logic [LEN_BITS-1:0] hdr_len_ff, hdr_len_in;
   logic                digit_seen_ff, digit_seen_in;
   logic                hdr_bad_ff, hdr_bad_in;
   logic [LEN_BITS-1:0] bytes_left_ff, bytes_left_in;
   logic [7:0]          frame_link_ff, frame_link_in;
   logic [7:0]          tail_ff [TAIL_LEN];
   logic [7:0]          tail_in [TAIL_LEN];
   logic [7:0]          lead_int_ff, lead_int_in;
   logic [1:0]          lead_phase_ff, lead_phase_in;

   // Result and skid registers
   logic    out_valid_ff, out_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   res_type out_res_ff, out_res_in;
   res_type skid_res_ff, skid_res_in;

   logic          req_accept, advance, take_out;
   logic [7:0]    b;
   logic          res_valid;
   res_type       res;
   logic          do_track, do_begin;
   logic          conn_hit, clos_hit, lv;
   logic [LEN_BITS+3:0] len_mac;
   logic [7:0]    dig;

   assign req_stall  = in_valid_ff && skid_valid_ff;
   assign req_accept = req_valid && !req_stall;
   assign advance    = in_valid_ff && !skid_valid_ff;
   assign take_out   = out_valid_ff && !rsp_stall;
   assign b          = in_byte_ff;

   assign in_valid_in = req_accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);

   always_comb begin
      conn_hit = 1'b1;
      for (int k = 0; k < CONN_LEN; k++) begin
         if (tail_ff[k+1] != SFX_CONN[k]) conn_hit = 1'b0;
      end
      clos_hit = 1'b1;
      for (int k = 0; k < CLOS_LEN; k++) begin
         if (tail_ff[k+1] != SFX_CLOS[k]) clos_hit = 1'b0;
      end
   end

   assign dig     = b - "0";
   assign len_mac = ({4'd0, hdr_len_ff} << 3) + ({4'd0, hdr_len_ff} << 1)
                    + (LEN_BITS+4)'(dig[3:0]);
   assign lv      = lead_phase_ff[0];

   always_comb begin
      mode_in       = mode_ff;
      prefix_pos_in = prefix_pos_ff;
      hdr_id_in     = hdr_id_ff;
      hdr_len_in    = hdr_len_ff;
      digit_seen_in = digit_seen_ff;
      hdr_bad_in    = hdr_bad_ff;
      bytes_left_in = bytes_left_ff;
      frame_link_in = frame_link_ff;
      tail_in       = tail_ff;
      lead_int_in   = lead_int_ff;
      lead_phase_in = lead_phase_ff;
      res_valid     = 1'b0;
      res           = '0;
      do_track      = 1'b0;
      do_begin      = 1'b0;

      if (advance) begin
         unique case (mode_ff) inside
            M_LSTART, M_LINE: begin
               if (mode_ff == M_LSTART && prefix_pos_ff < PFX_LEN
                   && b == pfx_char(prefix_pos_ff)) begin
                  do_track      = 1'b1;
                  prefix_pos_in = prefix_pos_ff + 3'd1;
                  if (prefix_pos_ff == PFX_LEN - 3'd1) begin
                     mode_in       = M_HID;
                     hdr_id_in     = '0;
                     hdr_len_in    = '0;
                     digit_seen_in = 1'b0;
                     hdr_bad_in    = 1'b0;
                  end
               end else if (b == CH_LF && tail_ff[0] == CH_CR) begin
                  do_begin = 1'b1;
                  if (conn_hit || clos_hit) begin
                     res_valid      = 1'b1;
                     res.kind       = conn_hit ? KIND_CONNECT : KIND_CLOSED;
                     res.link_valid = lv;
                     res.link       = lv ? lead_int_ff : 8'd0;
                  end
               end else begin
                  do_track = 1'b1;
                  mode_in  = M_LINE;
               end
            end
            M_HID, M_HLEN: begin
               if (b == CH_COLON) begin
                  if (hdr_bad_ff || mode_ff != M_HLEN || !digit_seen_ff) begin
                     do_begin  = 1'b1;
                     res_valid = 1'b1;
                     res.kind  = KIND_BAD_HDR;
                  end else if (hdr_len_ff == '0) begin
                     do_begin       = 1'b1;
                     res_valid      = 1'b1;
                     res.kind       = KIND_EMPTY;
                     res.link       = hdr_id_ff;
                     res.link_valid = 1'b1;
                  end else begin
                     frame_link_in = hdr_id_ff;
                     bytes_left_in = hdr_len_ff;
                     mode_in       = M_PAY;
                  end
               end else if (!hdr_bad_ff) begin
                  if (is_digit(b)) begin
                     digit_seen_in = 1'b1;
                     if (mode_ff == M_HID) begin
                        hdr_id_in = mac10_u8(hdr_id_ff, b);
                     end else begin
                        hdr_len_in = (|len_mac[LEN_BITS+3:LEN_BITS]) ? LEN_MAX
                                     : len_mac[LEN_BITS-1:0];
                     end
                  end else if (b == CH_COMMA && mode_ff == M_HID && digit_seen_ff) begin
                     mode_in       = M_HLEN;
                     digit_seen_in = 1'b0;
                  end else begin
                     hdr_bad_in = 1'b1;
                  end
               end
            end
            M_PAY: begin
               res_valid      = 1'b1;
               res.kind       = KIND_PAYLOAD;
               res.link       = frame_link_ff;
               res.link_valid = 1'b1;
               res.payload    = b;
               if (bytes_left_ff <= LEN_ONE) begin
                  bytes_left_in  = '0;
                  do_begin       = 1'b1;
                  res.frame_last = 1'b1;
               end else begin
                  bytes_left_in = bytes_left_ff - LEN_ONE;
               end
            end
            default: begin
               do_begin = 1'b1;
            end
         endcase
      end

      // Shift the line tail and follow the leading integer
      if (do_track) begin
         for (int k = TAIL_LEN - 1; k > 0; k--) begin
            tail_in[k] = tail_ff[k-1];
         end
         tail_in[0] = b;
         if (lead_phase_ff == LP_SKIP) begin
            if (is_digit(b)) begin
               lead_phase_in = LP_DIGITS;
               lead_int_in   = {4'd0, dig[3:0]};
            end else if (!is_space(b)) begin
               lead_phase_in = LP_DONE_NONE;
            end
         end else if (lead_phase_ff == LP_DIGITS) begin
            if (is_digit(b)) begin
               lead_int_in = mac10_u8(lead_int_ff, b);
            end else begin
               lead_phase_in = LP_DONE_INT;
            end
         end
      end

      if (do_begin) begin
         mode_in       = M_LSTART;
         prefix_pos_in = '0;
         for (int k = 0; k < TAIL_LEN; k++) begin
            tail_in[k] = '0;
         end
         lead_int_in   = '0;
         lead_phase_in = LP_SKIP;
      end
   end

   // Result register with one skid slot
   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_res_in    = out_res_ff;
      skid_res_in   = skid_res_ff;
      if (take_out) begin
         if (skid_valid_ff) begin
            out_res_in    = skid_res_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = 1'b0;
         end
      end
      if (res_valid) begin
         if (!out_valid_ff || take_out) begin
            out_res_in   = res;
            out_valid_in = 1'b1;
         end else begin
            skid_res_in   = res;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
         mode_ff       <= M_LSTART;
         prefix_pos_ff <= '0;
         hdr_id_ff     <= '0;
         hdr_len_ff    <= '0;
         digit_seen_ff <= 1'b0;
         hdr_bad_ff    <= 1'b0;
         bytes_left_ff <= '0;
         frame_link_ff <= '0;
         for (int k = 0; k < TAIL_LEN; k++) begin
            tail_ff[k] <= '0;
         end
         lead_int_ff   <= '0;
         lead_phase_ff <= LP_SKIP;
      end else begin
         in_valid_ff   <= in_valid_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
         mode_ff       <= mode_in;
         prefix_pos_ff <= prefix_pos_in;
         hdr_id_ff     <= hdr_id_in;
         hdr_len_ff    <= hdr_len_in;
         digit_seen_ff <= digit_seen_in;
         hdr_bad_ff    <= hdr_bad_in;
         bytes_left_ff <= bytes_left_in;
         frame_link_ff <= frame_link_in;
         tail_ff       <= tail_in;
         lead_int_ff   <= lead_int_in;
         lead_phase_ff <= lead_phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_byte_ff <= req_rx_byte;
      end
      out_res_ff  <= out_res_in;
      skid_res_ff <= skid_res_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_kind       = out_res_ff.kind;
   assign rsp_link       = out_res_ff.link;
   assign rsp_link_valid = out_res_ff.link_valid;
   assign rsp_payload    = out_res_ff.payload;
   assign rsp_frame_last = out_res_ff.frame_last;

   `AT_NEVER(a_skid_without_out, clock, reset, skid_valid_ff && !out_valid_ff)
   `AT_ASSERT(a_pay_has_bytes, clock, reset, (mode_ff == M_PAY) |-> (bytes_left_ff != '0))
   `AT_ASSERT(a_hdr_after_prefix, clock, reset, (mode_ff == M_HID || mode_ff == M_HLEN) |-> (prefix_pos_ff == PFX_LEN))
   `AT_ASSERT(a_last_is_payload, clock, reset, (rsp_valid && rsp_frame_last) |-> (rsp_kind == KIND_PAYLOAD))

endmodule
